### sv/mtc_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, constants and register indexes of the magnetometer compensation block.
package mtc_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_X_TRIM   = 3'd0;
	localparam logic [2:0] REG_Y_TRIM   = 3'd1;
	localparam logic [2:0] REG_XY_POLY  = 3'd2;
	localparam logic [2:0] REG_Z_GAIN   = 3'd3;
	localparam logic [2:0] REG_Z_BASE   = 3'd4;
	localparam logic [2:0] REG_Z_SLOPE  = 3'd5;
	localparam logic [2:0] REG_Z_OFFSET = 3'd6;
	localparam logic [2:0] REG_HALL_REF = 3'd7;

	localparam logic signed [12:0] XY_ADC_OVF = -13'sd4096;
	localparam logic signed [14:0] Z_ADC_OVF  = -15'sd16384;
	localparam logic signed [31:0] OVF_OUT    = -32'sd32768;
	localparam logic signed [31:0] OVF_WIDE   = 32'sh8000_0000;
	localparam logic signed [16:0] RATIO_ONE  = 17'sd16384;
	localparam logic signed [27:0] XY_BIAS    = 28'sh010_0000;
	localparam logic signed [9:0]  GAIN_BIAS  = 10'sd160;
	localparam logic [32:0]        Z_ROUND    = 33'd32768;

	// Divider: bits resolved per cycle and cycles per divide
	localparam int DIV_W     = 36;
	localparam int DIV_STEPS = 4;
	localparam int DIV_CYC   = DIV_W / DIV_STEPS;
	localparam logic [3:0] DIV_LAST = 4'(DIV_CYC - 1);

	typedef struct packed {
		logic [15:0]        x_trim;
		logic [15:0]        y_trim;
		logic [15:0]        xy_poly;
		logic [15:0]        z_gain;
		logic signed [15:0] z_base;
		logic signed [15:0] z_slope;
		logic signed [15:0] z_offset;
		logic [15:0]        hall_ref;
	} cfg_t;

	// Classified frame passed from front to back
	typedef struct packed {
		logic signed [12:0] mx;
		logic signed [12:0] my;
		logic signed [14:0] mz;
		logic [13:0]        rh;
		logic               ovf_x;
		logic               ovf_y;
		logic               ovf_z;
	} item_t;

endpackage

### sv/mtc_if.sv
`timescale 1ns / 1ps
// Interfaces: input frame channel and compensated result channel.
interface mtc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] raw_x_word;
	logic signed [15:0] raw_y_word;
	logic signed [15:0] raw_z_word;
	logic [15:0]        raw_hall_word;
	modport source (output valid, raw_x_word, raw_y_word, raw_z_word, raw_hall_word,
		input ready);
	modport sink (input valid, raw_x_word, raw_y_word, raw_z_word, raw_hall_word,
		output ready);
endinterface

interface mtc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] comp_x;
	logic signed [31:0] comp_y;
	logic signed [31:0] comp_z;
	modport source (output valid, comp_x, comp_y, comp_z, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

### sv/magnetometer_temp_compensation.sv
`timescale 1ns / 1ps
// Top level: magnetometer Hall-resistance temperature compensation.
// Path: front register, queue, then the back-end sequence with a radix-16 divide of the
// Z and ratio terms. The single back-end sequencer and its divider take one frame at a time.
// The front end and two-entry queue keep accepting while the back end works.
// Reset (arst_n, async low) clears the configuration, handshake state and sequencer;
// datapath registers are not reset.
module magnetometer_temp_compensation (
	input  logic        clk,
	input  logic        arst_n,
	mtc_in_if.sink      in_ch,
	mtc_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	mtc_pkg::cfg_t  cfg_q;
	logic           push;
	logic           push_ready;
	mtc_pkg::item_t push_item;
	logic           pop;
	logic           pop_valid;
	mtc_pkg::item_t pop_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mtc_pkg::REG_X_TRIM:   cfg_q.x_trim   <= cfg_wdata;
				mtc_pkg::REG_Y_TRIM:   cfg_q.y_trim   <= cfg_wdata;
				mtc_pkg::REG_XY_POLY:  cfg_q.xy_poly  <= cfg_wdata;
				mtc_pkg::REG_Z_GAIN:   cfg_q.z_gain   <= cfg_wdata;
				mtc_pkg::REG_Z_BASE:   cfg_q.z_base   <= $signed(cfg_wdata);
				mtc_pkg::REG_Z_SLOPE:  cfg_q.z_slope  <= $signed(cfg_wdata);
				mtc_pkg::REG_Z_OFFSET: cfg_q.z_offset <= $signed(cfg_wdata);
				mtc_pkg::REG_HALL_REF: cfg_q.hall_ref <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mtc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg_q),
		.push(push), .push_item(push_item), .push_ready(push_ready)
	);

	mtc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.push_ready(push_ready), .pop(pop), .pop_valid(pop_valid), .pop_item(pop_item)
	);

	mtc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .pop_valid(pop_valid),
		.pop_item(pop_item), .pop(pop), .out_ch(out_ch)
	);
endmodule

### sv/mtc_front.sv
`timescale 1ns / 1ps
// Front end: takes raw frames, scales the words and flags the sentinel cases.
module mtc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	mtc_in_if.sink               in_ch,
	input  mtc_pkg::cfg_t        cfg,
	output logic                 push,
	output mtc_pkg::item_t       push_item,
	input  logic                 push_ready
);
	logic           valid_s1;
	mtc_pkg::item_t item_s1;
	mtc_pkg::item_t item_d;
	logic           acc;

	assign in_ch.ready = !valid_s1 || push_ready;
	assign acc         = in_ch.valid && in_ch.ready;
	assign push        = valid_s1;
	assign push_item   = item_s1;

	// Scale raw words and classify
	always_comb begin
		item_d.mx    = 13'(in_ch.raw_x_word >>> 3);
		item_d.my    = 13'(in_ch.raw_y_word >>> 3);
		item_d.mz    = 15'(in_ch.raw_z_word >>> 1);
		item_d.rh    = in_ch.raw_hall_word[15:2];
		item_d.ovf_x = (item_d.mx == mtc_pkg::XY_ADC_OVF) || (item_d.rh == '0)
			|| (cfg.hall_ref == '0);
		item_d.ovf_y = (item_d.my == mtc_pkg::XY_ADC_OVF) || (item_d.rh == '0)
			|| (cfg.hall_ref == '0);
		item_d.ovf_z = (item_d.mz == mtc_pkg::Z_ADC_OVF) || (item_d.rh == '0)
			|| (cfg.z_gain == '0) || (cfg.z_base == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_d;
		end
	end
endmodule

### sv/mtc_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module mtc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtc_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output mtc_pkg::item_t pop_item
);
	mtc_pkg::item_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end
endmodule

### sv/mtc_back.sv
`timescale 1ns / 1ps
// Back end: sequenced compensation datapath with two radix-16 restoring dividers.
module mtc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mtc_pkg::cfg_t  cfg,
	input  logic           pop_valid,
	input  mtc_pkg::item_t pop_item,
	output logic           pop,
	mtc_out_if.source      out_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_LOAD, S_DIV, S_POLY1, S_POLY2, S_POLY3, S_GAIN, S_MUL, S_FIN
	} state_t;

	state_t state_q;
	logic [3:0] cyc_q;
	mtc_pkg::item_t item_q;

	logic signed [18:0] zden_q;
	logic signed [32:0] zprod_q;
	logic               zneg_q;
	logic               zdz_q;
	logic [18:0]        zd_q;
	logic [19:0]        zrem_q;
	logic [35:0]        zquo_q;
	logic [13:0]        rd_q;
	logic [14:0]        rrem_q;
	logic [35:0]        rquo_q;
	logic signed [31:0] zres_q;
	logic signed [33:0] rr_q;
	logic signed [32:0] t2_q;
	logic signed [34:0] t1_q;
	logic signed [27:0] t3_q;
	logic signed [37:0] px_q;
	logic signed [37:0] py_q;
	logic signed [38:0] t4x_q;
	logic signed [38:0] t4y_q;
	logic               out_valid_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [31:0] cz_q;

	// Combinational terms
	logic signed [16:0] hdiff;
	logic signed [32:0] zprod_d;
	logic [29:0]        zmul;
	logic [32:0]        zsum;
	logic signed [18:0] zden_d;
	logic signed [16:0] mzd;
	logic signed [35:0] znum;
	logic [19:0]        zrem_n;
	logic [35:0]        zquo_n;
	logic [14:0]        rrem_n;
	logic [35:0]        rquo_n;
	logic signed [16:0] r;
	logic signed [25:0] rxy;
	logic signed [36:0] zq;
	logic signed [35:0] tsum;
	logic signed [9:0]  gx;
	logic signed [9:0]  gy;
	logic signed [31:0] resx;
	logic signed [31:0] resy;
	logic signed [7:0]  xy2;
	logic signed [7:0]  offx;
	logic signed [7:0]  offy;
	logic               out_free;

	assign pop             = (state_q == S_IDLE) && pop_valid;
	assign out_free        = !out_valid_q || out_ch.ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.comp_x   = cx_q;
	assign out_ch.comp_y   = cy_q;
	assign out_ch.comp_z   = cz_q;
	assign xy2             = $signed(cfg.xy_poly[15:8]);
	assign offx            = $signed(cfg.x_trim[7:0]);
	assign offy            = $signed(cfg.y_trim[7:0]);

	// Z numerator and divisor terms
	always_comb begin
		hdiff   = $signed({3'b000, item_q.rh}) - $signed({cfg.hall_ref[15], cfg.hall_ref});
		zprod_d = cfg.z_slope * hdiff;
		zmul    = cfg.z_gain * item_q.rh;
		zsum    = {2'b00, zmul, 1'b0} + mtc_pkg::Z_ROUND;
		zden_d  = $signed({{3{cfg.z_base[15]}}, cfg.z_base}) + $signed({2'b00, zsum[32:16]});
		mzd     = $signed({{2{item_q.mz[14]}}, item_q.mz})
			- $signed({cfg.z_offset[15], cfg.z_offset});
		znum    = $signed({{4{mzd[16]}}, mzd, 15'b0})
			- $signed({{5{zprod_q[32]}}, zprod_q[32:2]});
	end

	// Four restoring steps per cycle on both dividers
	always_comb begin
		zrem_n = zrem_q;
		zquo_n = zquo_q;
		rrem_n = rrem_q;
		rquo_n = rquo_q;
		for (int k = 0; k < mtc_pkg::DIV_STEPS; k++) begin
			zrem_n = {zrem_n[18:0], zquo_n[35]};
			zquo_n = {zquo_n[34:0], 1'b0};
			if (zrem_n >= {1'b0, zd_q}) begin
				zrem_n    = zrem_n - {1'b0, zd_q};
				zquo_n[0] = 1'b1;
			end
			rrem_n = {rrem_n[13:0], rquo_n[35]};
			rquo_n = {rquo_n[34:0], 1'b0};
			if (rrem_n >= {1'b0, rd_q}) begin
				rrem_n    = rrem_n - {1'b0, rd_q};
				rquo_n[0] = 1'b1;
			end
		end
	end

	// Polynomial and finishing terms
	always_comb begin
		r    = $signed({1'b0, rquo_q[15:0]}) - mtc_pkg::RATIO_ONE;
		rxy  = r * $signed({1'b0, cfg.xy_poly[7:0]});
		zq   = zneg_q ? -$signed({1'b0, zquo_q}) : $signed({1'b0, zquo_q});
		tsum = 36'(t1_q) + 36'(t2_q);
		gx   = $signed({{2{cfg.x_trim[15]}}, cfg.x_trim[15:8]}) + mtc_pkg::GAIN_BIAS;
		gy   = $signed({{2{cfg.y_trim[15]}}, cfg.y_trim[15:8]}) + mtc_pkg::GAIN_BIAS;
		resx = 32'(t4x_q >>> 13) + $signed({{21{offx[7]}}, offx, 3'b000});
		resy = 32'(t4y_q >>> 13) + $signed({{21{offy[7]}}, offy, 3'b000});
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cyc_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (pop_valid) state_q <= S_PREP;
				S_PREP:  state_q <= S_LOAD;
				S_LOAD: begin
					state_q <= S_DIV;
					cyc_q   <= 4'd0;
				end
				S_DIV: begin
					cyc_q <= cyc_q + 4'd1;
					if (cyc_q == mtc_pkg::DIV_LAST) state_q <= S_POLY1;
				end
				S_POLY1: state_q <= S_POLY2;
				S_POLY2: state_q <= S_POLY3;
				S_POLY3: state_q <= S_GAIN;
				S_GAIN:  state_q <= S_MUL;
				S_MUL:   state_q <= S_FIN;
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (pop_valid) item_q <= pop_item;
			S_PREP: begin
				zprod_q <= zprod_d;
				zden_q  <= zden_d;
			end
			S_LOAD: begin
				zneg_q <= znum[35] ^ zden_q[18];
				zdz_q  <= (zden_q == '0);
				zd_q   <= zden_q[18] ? 19'(-zden_q) : 19'(zden_q);
				zquo_q <= znum[35] ? 36'(-znum) : 36'(znum);
				zrem_q <= '0;
				rd_q   <= item_q.rh;
				rquo_q <= {6'b0, cfg.hall_ref, 14'b0};
				rrem_q <= '0;
			end
			S_DIV: begin
				zrem_q <= zrem_n;
				zquo_q <= zquo_n;
				rrem_q <= rrem_n;
				rquo_q <= rquo_n;
			end
			S_POLY1: begin
				rr_q <= r * r;
				t2_q <= {{7{rxy[25]}}, rxy} <<< 7;
				if (zq > 37'sd2147483647) zres_q <= 32'sh7fff_ffff;
				else if (zq < -37'sd2147483648) zres_q <= mtc_pkg::OVF_WIDE;
				else zres_q <= 32'(zq);
			end
			S_POLY2: t1_q <= xy2 * 27'(rr_q >>> 7);
			S_POLY3: t3_q <= 28'(tsum >>> 9) + mtc_pkg::XY_BIAS;
			S_GAIN: begin
				px_q <= t3_q * gx;
				py_q <= t3_q * gy;
			end
			S_MUL: begin
				t4x_q <= item_q.mx * 26'(px_q >>> 12);
				t4y_q <= item_q.my * 26'(py_q >>> 12);
			end
			S_FIN: begin
				if (out_free) begin
					if (item_q.ovf_x) cx_q <= mtc_pkg::OVF_OUT;
					else if (resx == mtc_pkg::OVF_OUT) cx_q <= mtc_pkg::OVF_WIDE;
					else cx_q <= resx;
					if (item_q.ovf_y) cy_q <= mtc_pkg::OVF_OUT;
					else if (resy == mtc_pkg::OVF_OUT) cy_q <= mtc_pkg::OVF_WIDE;
					else cy_q <= resy;
					if (item_q.ovf_z || zdz_q) cz_q <= mtc_pkg::OVF_OUT;
					else cz_q <= zres_q;
				end
			end
			default: ;
		endcase
	end
endmodule

### sv/mtc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the compensation block, bound to the top level.
module mtc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0) else $error("result without a request");
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd5 |-> !in_ready) else $error("accepted beyond capacity");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd5) else $error("in-flight count overflow");
endmodule

bind magnetometer_temp_compensation mtc_checker u_mtc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
